FILE: rtl/core/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the counting semaphore bank: request actions,
// table entry view and the write-back command from the control to the store.
// ----------------------------------------------------------------------------
package csb_pkg;

   localparam int SLOT_W       = 8;
   localparam int COUNT_W      = 32;
   localparam int MAG_W        = 31;
   localparam int HANDLE_LIMIT = 256;

   localparam logic [MAG_W-1:0]   COUNT_MAX = 31'h7fff_ffff;
   localparam logic [COUNT_W-1:0] FREE_MARK = 32'hffff_ffff;

   typedef enum logic [1:0] {
      ACT_CREATE  = 2'd0,
      ACT_DESTROY = 2'd1,
      ACT_TAKE    = 2'd2,
      ACT_GIVE    = 2'd3
   } action_type;

   // entry as read from the store: free flag and the non-negative count
   typedef struct packed {
      logic             free;
      logic [MAG_W-1:0] count;
   } entry_type;

   // write-back of one request into the store
   typedef struct packed {
      logic              wr_en;
      logic              set_free;
      logic              clr_free;
      logic [SLOT_W-1:0] idx;
      logic [MAG_W-1:0]  count;
   } wr_cmd_type;

endpackage

FILE: rtl/core/csb_store.sv
// ----------------------------------------------------------------------------
// csb_store
// Count memory with registered read, free bitmap in flip-flops and
// the lowest-free-slot search used by create.
// ----------------------------------------------------------------------------
module csb_store
   import csb_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_idx,
   output entry_type         rd_entry,
   input  wr_cmd_type        wr,
   output logic              alloc_found,
   output logic [SLOT_W-1:0] alloc_idx
);

   logic [MAG_W-1:0] mem_ff [DEPTH];
   logic [MAG_W-1:0] rd_data_ff;
   logic [DEPTH-1:0] free_ff;
   logic [DEPTH-1:0] free_in;
   logic             zero_ff;
   logic             zero_in;
   logic             rd_free_ff;
   logic             rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem_ff[wr.idx[AW-1:0]] <= wr.count;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx[AW-1:0]];
      end
   end

   always_comb begin
      free_in = free_ff;
      if (wr.set_free) begin
         free_in[wr.idx[AW-1:0]] = 1'b1;
      end
      if (wr.clr_free) begin
         free_in[wr.idx[AW-1:0]] = 1'b0;
      end
      // slot zero starts in use with count 0 until its entry is first written
      zero_in = zero_ff && !(wr.wr_en && wr.idx[AW-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff    <= {{(DEPTH-1){1'b1}}, 1'b0};
         zero_ff    <= 1'b1;
         rd_free_ff <= 1'b1;
         rd_zero_ff <= 1'b0;
      end else begin
         free_ff <= free_in;
         zero_ff <= zero_in;
         if (rd_en) begin
            rd_free_ff <= free_ff[rd_idx[AW-1:0]];
            rd_zero_ff <= zero_ff && rd_idx[AW-1:0] == '0;
         end
      end
   end

   assign rd_entry.free  = rd_free_ff;
   assign rd_entry.count = rd_zero_ff ? '0 : rd_data_ff;

   // lowest free slot from 1 upward
   always_comb begin
      alloc_found = 1'b0;
      alloc_idx   = '0;
      for (int i = DEPTH - 1; i >= 1; i--) begin
         if (free_ff[i]) begin
            alloc_found = 1'b1;
            alloc_idx   = SLOT_W'(i);
         end
      end
   end

endmodule

FILE: rtl/core/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Request sequencer: latches an item and issues the table read, then decides
// the action on the read entry, writes it back and loads the result register.
// ----------------------------------------------------------------------------
module csb_ctrl
   import csb_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rd_en,
   output logic [SLOT_W-1:0] rd_idx,
   input  entry_type         rd_entry,
   input  logic              alloc_found,
   input  logic [SLOT_W-1:0] alloc_idx,
   output wr_cmd_type        wr
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type           state_ff, state_in;
   action_type          act_ff, act_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [COUNT_W-1:0]  init_ff, init_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                succ_ff, succ_in;
   logic [SLOT_W-1:0]   handle_ff, handle_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                req_fire;
   logic                done;
   logic                in_range;
   logic                in_use;
   wr_cmd_type          cmd;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rd_en      = req_fire;
   assign rd_idx     = req_tdata[SLOT_W-1:0];

   // write-back waits until the result register can take the item
   assign done     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign in_range = {1'b0, slot_ff} < 9'(DEPTH);
   assign in_use   = in_range && !rd_entry.free;

   always_comb begin
      cmd       = '0;
      cmd.idx   = slot_ff;
      succ_in   = 1'b0;
      handle_in = '0;
      cnt_in    = FREE_MARK;
      case (act_ff)
         ACT_CREATE: begin
            cmd.idx   = alloc_idx;
            cmd.count = init_ff[MAG_W-1:0];
            if (!init_ff[COUNT_W-1] && alloc_found) begin
               cmd.wr_en    = 1'b1;
               cmd.clr_free = 1'b1;
               succ_in      = 1'b1;
               handle_in    = alloc_idx;
            end
         end
         ACT_DESTROY: begin
            if (in_use) begin
               cmd.set_free = 1'b1;
               succ_in      = 1'b1;
            end
         end
         ACT_TAKE: begin
            cmd.count = rd_entry.count - 1'b1;
            if (in_use && rd_entry.count != '0) begin
               cmd.wr_en = 1'b1;
               succ_in   = 1'b1;
               cnt_in    = {1'b0, cmd.count};
            end
         end
         ACT_GIVE: begin
            cmd.count = rd_entry.count + 1'b1;
            if (in_use) begin
               cmd.wr_en = (rd_entry.count != COUNT_MAX);
               succ_in   = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
      wr          = cmd;
      wr.wr_en    = cmd.wr_en && done;
      wr.set_free = cmd.set_free && done;
      wr.clr_free = cmd.clr_free && done;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      slot_in      = slot_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
               act_in   = action_type'(req_tuser);
               slot_in  = req_tdata[SLOT_W-1:0];
               init_in  = req_tdata[39:8];
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff  <= act_in;
      slot_ff <= slot_in;
      init_ff <= init_in;
      if (done) begin
         succ_ff   <= succ_in;
         handle_ff <= handle_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = succ_ff;
   assign rsp_tdata  = {cnt_ff, handle_ff};

endmodule

FILE: rtl/core/counting_semaphore_bank.sv
// ----------------------------------------------------------------------------
// counting_semaphore_bank
// Bank of counting semaphores: create, destroy, take (non-blocking) and give
// on a table of non-negative counts, a free bitmap marking free slots.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                 | tuser
//  req_    | in  | slot[7:0], initial_count[39:8]     | action[1:0]
//  rsp_    | out | handle[7:0], count_after[39:8]     | success[0]
//
// each item: a registered read of the count memory, then the modify and
// write-back of that entry with the result register load; only then is the
// next item taken, even while the previous result still waits on rsp_tready;
// it holds in the execute state until the result register is free.
// reset frees every slot but slot 0 at once (free bitmap in flip-flops),
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module counting_semaphore_bank
   import csb_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[7:0], initial_count[39:8]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // handle[7:0], count_after[39:8]
   output logic        rsp_tuser    // success[0]
);

   // only slots below the 8-bit handle range can ever be named
   localparam int DEPTH = (SLOTS < HANDLE_LIMIT) ? SLOTS : HANDLE_LIMIT;
   localparam int AW    = $clog2(DEPTH);

   logic              rd_en;
   logic [SLOT_W-1:0] rd_idx;
   entry_type         rd_entry;
   wr_cmd_type        wr;
   logic              alloc_found;
   logic [SLOT_W-1:0] alloc_idx;

   csb_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rd_en       (rd_en),
      .rd_idx      (rd_idx),
      .rd_entry    (rd_entry),
      .alloc_found (alloc_found),
      .alloc_idx   (alloc_idx),
      .wr          (wr)
   );

   csb_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_idx      (rd_idx),
      .rd_entry    (rd_entry),
      .wr          (wr),
      .alloc_found (alloc_found),
      .alloc_idx   (alloc_idx)
   );

endmodule

FILE: rtl/core/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks of the counting semaphore bank, bound to the top level.
// ----------------------------------------------------------------------------
module csb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // result stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed or dropped while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   // with the result side empty, an item passes the execute state, then shows its result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing after item");

   // a nonzero handle only comes from a successful create
   a_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] != 8'd0 |-> rsp_tuser && rsp_tdata[39:8] == 32'hffff_ffff)
      else $error("handle on a result that is not a create");

endmodule

bind counting_semaphore_bank csb_checker u_csb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
